/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file of the lexer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, skipped while reset is high.
`define CLT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lexer assertion failed");

// Property checked on every rising edge, reset included.
`define CLT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lexer assertion failed");

`endif

/* src/clt_pkg.sv */
// ----------------------------------------------------------------------------
// clt_pkg
// Shared sizes, token codes, result record and keyword table of the lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package clt_pkg;

  // Text buffer depth and the widths that follow from it.
  localparam int MAX_TEXT = 32;
  localparam int TEXT_AW  = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
  localparam int LEN_W    = $clog2(MAX_TEXT + 1);

  localparam int NUM_KW = 12;
  localparam int KW_MAX = 6;

  typedef logic [5:0] code_t;

  // Token codes.
  localparam code_t TOK_END    = 6'd0;
  localparam code_t TOK_IDENT  = 6'd10;
  localparam code_t TOK_INT    = 6'd20;
  localparam code_t TOK_ASSIGN = 6'd21;
  localparam code_t TOK_PLUS   = 6'd22;
  localparam code_t TOK_MINUS  = 6'd23;
  localparam code_t TOK_STAR   = 6'd24;
  localparam code_t TOK_SLASH  = 6'd25;
  localparam code_t TOK_LPAR   = 6'd26;
  localparam code_t TOK_RPAR   = 6'd27;
  localparam code_t TOK_LBRK   = 6'd28;
  localparam code_t TOK_RBRK   = 6'd29;
  localparam code_t TOK_LBRC   = 6'd30;
  localparam code_t TOK_RBRC   = 6'd31;
  localparam code_t TOK_COMMA  = 6'd32;
  localparam code_t TOK_COLON  = 6'd33;
  localparam code_t TOK_SEMI   = 6'd34;
  localparam code_t TOK_GT     = 6'd35;
  localparam code_t TOK_LT     = 6'd36;
  localparam code_t TOK_GE     = 6'd37;
  localparam code_t TOK_LE     = 6'd38;
  localparam code_t TOK_EQ     = 6'd39;
  localparam code_t TOK_NE     = 6'd40;
  localparam code_t TOK_STRING = 6'd50;
  localparam code_t TOK_ERROR  = 6'd51;

  // One result transaction.
  typedef struct packed {
    code_t       code;
    logic [30:0] value;
    logic [7:0]  text_char;
    logic [4:0]  text_index;
    logic        truncated;
    logic        last;
  } result_t;

  // Keyword spellings, zero padded; keyword n has code n + 1.
  localparam logic [7:0] KW_CHARS [NUM_KW][KW_MAX] = '{
    '{8'h6D, 8'h61, 8'h69, 8'h6E, 8'h00, 8'h00},  // main
    '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00},  // int
    '{8'h63, 8'h68, 8'h61, 8'h72, 8'h00, 8'h00},  // char
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},  // if
    '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00},  // else
    '{8'h66, 8'h6F, 8'h72, 8'h00, 8'h00, 8'h00},  // for
    '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65, 8'h00},  // while
    '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E},  // return
    '{8'h76, 8'h6F, 8'h69, 8'h64, 8'h00, 8'h00},  // void
    '{8'h53, 8'h54, 8'h52, 8'h49, 8'h4E, 8'h47},  // STRING
    '{8'h49, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00},  // ID
    '{8'h49, 8'h4E, 8'h54, 8'h00, 8'h00, 8'h00}   // INT
  };

  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd4, 3'd6, 3'd2, 3'd3
  };

  // Character of keyword w at position pos, zero past its end.
  function automatic logic [7:0] kw_char(input logic [3:0] w,
                                         input logic [LEN_W-1:0] pos);
    logic [7:0] r;
    r = 8'h00;
    if (pos < LEN_W'(KW_MAX)) begin
      r = KW_CHARS[w][pos[2:0]];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/clt_text_mem.sv */
// ----------------------------------------------------------------------------
// clt_text_mem
// Text buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_text_mem (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [clt_pkg::TEXT_AW-1:0] waddr,
  input  wire logic [7:0]                 wdata,
  input  wire logic                       re,
  input  wire logic [clt_pkg::TEXT_AW-1:0] raddr,
  output logic      [7:0]                 rdata
);

  logic [7:0] mem [clt_pkg::MAX_TEXT];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/clt_out_stage.sv */
// ----------------------------------------------------------------------------
// clt_out_stage
// Output register of the result stream; frees the core while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire clt_pkg::result_t item,
  output logic                  free,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [47:0]           m_tdata,  // number_value, text_char, text_index, zero pad
  output logic [6:0]            m_tuser,  // token_code, truncated
  output logic                  m_tlast   // last
);

  clt_pkg::result_t held;

  // A new result may enter when the register is empty or being drained.
  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      held <= item;
    end
  end

  assign m_tdata = {4'b0000, held.text_index, held.text_char, held.value};
  assign m_tuser = {held.truncated, held.code};
  assign m_tlast = held.last;

endmodule

`default_nettype wire

/* src/c_subset_lexer.sv */
// ----------------------------------------------------------------------------
// c_subset_lexer
// Character-serial tokenizer for a small C subset.
// ----------------------------------------------------------------------------
// One character is taken per transaction while the sequencer is idle; a
// character that only extends a token leaves the sequencer idle. Each
// single-item token (operator, integer, end, error) then passes through
// S_PRE or S_POST into the output register, and each character of
// identifier or string text passes through S_RD, which reads the text
// buffer, and S_DAT, which loads the output register; both loads wait while
// the output register is full. A quote that directly follows an identifier
// is written to the text buffer only after that flush, in S_POST, which
// yields no result. The text buffer has registered read data; every write
// lands before the first read of a flush, so no forwarding is needed. The
// output register holds the last result while the next character is
// accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module c_subset_lexer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // ch
  input  wire logic [0:0]  s_tuser,   // new_line
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // number_value, text_char, text_index, zero pad
  output logic [6:0]       m_tuser,   // token_code, truncated
  output logic             m_tlast    // last
);

  localparam int LW = clt_pkg::LEN_W;
  localparam int AW = clt_pkg::TEXT_AW;

  // Pending token kinds.
  localparam logic [2:0] K_IDLE  = 3'd0;
  localparam logic [2:0] K_NUM   = 3'd1;
  localparam logic [2:0] K_IDENT = 3'd2;
  localparam logic [2:0] K_STR   = 3'd3;
  localparam logic [2:0] K_EQ    = 3'd4;
  localparam logic [2:0] K_GT    = 3'd5;
  localparam logic [2:0] K_LT    = 3'd6;
  localparam logic [2:0] K_BANG  = 3'd7;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRE  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_DAT  = 3'd3;
  localparam logic [2:0] S_POST = 3'd4;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_BANG  = 8'h21;

  // Token state.
  logic [2:0]                  state, state_next;
  logic [2:0]                  kind, kind_next;
  logic [LW-1:0]               len, len_next;
  logic                        ovf, ovf_next;
  logic [30:0]                 acc, acc_next;
  logic                        halted, halted_next;
  logic [clt_pkg::NUM_KW-1:0]  match, match_next;

  // Emission plan of the accepted character.
  clt_pkg::code_t pre_code, pre_code_next;
  logic [30:0]    pre_value, pre_value_next;
  clt_pkg::code_t f_code, f_code_next;
  logic [LW-1:0]  f_len, f_len_next;
  logic           f_ovf, f_ovf_next;
  logic           post_en, post_en_next;
  clt_pkg::code_t post_code, post_code_next;
  logic           post_wr, post_wr_next;
  logic [7:0]     post_char;
  logic [LW-1:0]  fidx, fidx_next;

  logic           pre_en, flush_en, start_go, wr_now;
  logic [AW-1:0]  wr_addr_now;

  // Effective state once new_line has been applied.
  logic [2:0]                 e_kind;
  logic [LW-1:0]              e_len;
  logic                       e_ovf, e_halt, room;
  logic [30:0]                e_acc;
  logic [clt_pkg::NUM_KW-1:0] e_match;
  clt_pkg::code_t             id_code;
  logic [34:0]                acc_sum;
  logic                       is_digit, is_alpha;

  logic             fire;
  logic [7:0]       ch;
  logic             new_line;
  logic             load, free;
  clt_pkg::result_t item;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata, mem_rdata;
  logic             text_last;

  assign ch       = s_tdata;
  assign new_line = s_tuser[0];
  assign s_tready = (state == S_IDLE);
  assign fire     = s_tvalid && s_tready;

  // Apply new_line, classify the character, and pick the identifier code.
  always_comb begin
    e_kind  = new_line ? K_IDLE : kind;
    e_len   = new_line ? '0 : len;
    e_ovf   = new_line ? 1'b0 : ovf;
    e_acc   = new_line ? '0 : acc;
    e_halt  = new_line ? 1'b0 : halted;
    e_match = new_line ? '1 : match;
    room    = e_len < LW'(clt_pkg::MAX_TEXT);
    is_digit = (ch >= 8'h30) && (ch <= 8'h39);
    is_alpha = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
    acc_sum = 35'({e_acc, 3'b000}) + 35'({e_acc, 1'b0}) + 35'(ch[3:0]);
    id_code = clt_pkg::TOK_IDENT;
    if (!e_ovf) begin
      for (int w = 0; w < clt_pkg::NUM_KW; w++) begin
        if (e_match[w] && (e_len == LW'(clt_pkg::KW_LEN[w]))) begin
          id_code = clt_pkg::code_t'(w + 1);
        end
      end
    end
  end

  // Decide the state update and the tokens caused by the character.
  always_comb begin
    kind_next      = e_kind;
    len_next       = e_len;
    ovf_next       = e_ovf;
    acc_next       = e_acc;
    halted_next    = e_halt;
    match_next     = e_match;
    pre_en         = 1'b0;
    pre_code_next  = clt_pkg::TOK_END;
    pre_value_next = '0;
    flush_en       = 1'b0;
    f_code_next    = clt_pkg::TOK_STRING;
    f_len_next     = e_len;
    f_ovf_next     = e_ovf;
    post_en_next   = 1'b0;
    post_code_next = clt_pkg::TOK_END;
    post_wr_next   = 1'b0;
    wr_now         = 1'b0;
    wr_addr_now    = e_len[AW-1:0];
    start_go       = 1'b0;

    if (!e_halt) begin
      unique case (e_kind)
        K_NUM: begin
          if (is_digit) begin
            acc_next = (acc_sum > 35'h7FFF_FFFF) ? 31'h7FFF_FFFF : acc_sum[30:0];
          end else begin
            pre_en         = 1'b1;
            pre_code_next  = clt_pkg::TOK_INT;
            pre_value_next = e_acc;
            start_go       = 1'b1;
          end
        end
        K_IDENT: begin
          if (is_digit || is_alpha) begin
            if (room) begin
              wr_now   = 1'b1;
              len_next = e_len + 1'b1;
              for (int w = 0; w < clt_pkg::NUM_KW; w++) begin
                match_next[w] = e_match[w] && (clt_pkg::kw_char(4'(w), e_len) == ch);
              end
            end else begin
              ovf_next = 1'b1;
            end
          end else begin
            flush_en    = 1'b1;
            f_code_next = id_code;
            start_go    = 1'b1;
          end
        end
        K_STR: begin
          if (ch == CH_HASH) begin
            pre_en        = 1'b1;
            pre_code_next = clt_pkg::TOK_ERROR;
            halted_next   = 1'b1;
            kind_next     = K_IDLE;
            len_next      = '0;
            ovf_next      = 1'b0;
          end else begin
            // The character is text, the closing quote included.
            if (room) begin
              wr_now   = 1'b1;
              len_next = e_len + 1'b1;
            end else begin
              ovf_next = 1'b1;
            end
            if (ch == CH_QUOTE) begin
              flush_en   = 1'b1;
              f_len_next = room ? e_len + 1'b1 : e_len;
              f_ovf_next = e_ovf || !room;
              kind_next  = K_IDLE;
              len_next   = '0;
              ovf_next   = 1'b0;
            end
          end
        end
        K_EQ, K_GT, K_LT: begin
          pre_en = 1'b1;
          if (ch == CH_EQ) begin
            pre_code_next = (e_kind == K_EQ) ? clt_pkg::TOK_EQ :
                            (e_kind == K_GT) ? clt_pkg::TOK_GE : clt_pkg::TOK_LE;
            kind_next     = K_IDLE;
          end else begin
            pre_code_next = (e_kind == K_EQ) ? clt_pkg::TOK_ASSIGN :
                            (e_kind == K_GT) ? clt_pkg::TOK_GT : clt_pkg::TOK_LT;
            start_go      = 1'b1;
          end
        end
        K_BANG: begin
          pre_en    = 1'b1;
          kind_next = K_IDLE;
          if (ch == CH_EQ) begin
            pre_code_next = clt_pkg::TOK_NE;
          end else begin
            // A lone bang swallows the character after it.
            pre_code_next = clt_pkg::TOK_ERROR;
            halted_next   = 1'b1;
          end
        end
        default: begin
          start_go = 1'b1;
        end
      endcase
    end

    // Start a new token from a cleared state.
    if (start_go) begin
      kind_next   = K_IDLE;
      len_next    = '0;
      ovf_next    = 1'b0;
      acc_next    = '0;
      match_next  = '1;
      wr_addr_now = '0;
      post_en_next = 1'b1;
      unique case (ch)
        CH_SPACE: post_en_next = 1'b0;
        CH_EQ: begin
          post_en_next = 1'b0;
          kind_next    = K_EQ;
        end
        CH_GT: begin
          post_en_next = 1'b0;
          kind_next    = K_GT;
        end
        CH_LT: begin
          post_en_next = 1'b0;
          kind_next    = K_LT;
        end
        CH_BANG: begin
          post_en_next = 1'b0;
          kind_next    = K_BANG;
        end
        CH_QUOTE: begin
          // After a flush the buffer is still being read, so the write waits.
          post_en_next = 1'b0;
          kind_next    = K_STR;
          len_next     = LW'(1);
          wr_now       = !flush_en;
          post_wr_next = flush_en;
        end
        8'h2B: post_code_next = clt_pkg::TOK_PLUS;
        8'h2D: post_code_next = clt_pkg::TOK_MINUS;
        8'h2A: post_code_next = clt_pkg::TOK_STAR;
        8'h2F: post_code_next = clt_pkg::TOK_SLASH;
        8'h28: post_code_next = clt_pkg::TOK_LPAR;
        8'h29: post_code_next = clt_pkg::TOK_RPAR;
        8'h5B: post_code_next = clt_pkg::TOK_LBRK;
        8'h5D: post_code_next = clt_pkg::TOK_RBRK;
        8'h7B: post_code_next = clt_pkg::TOK_LBRC;
        8'h7D: post_code_next = clt_pkg::TOK_RBRC;
        8'h2C: post_code_next = clt_pkg::TOK_COMMA;
        8'h3A: post_code_next = clt_pkg::TOK_COLON;
        8'h3B: post_code_next = clt_pkg::TOK_SEMI;
        CH_HASH: begin
          post_code_next = clt_pkg::TOK_END;
          halted_next    = 1'b1;
        end
        default: begin
          if (is_digit) begin
            post_en_next = 1'b0;
            kind_next    = K_NUM;
            acc_next     = 31'(ch[3:0]);
          end else if (is_alpha) begin
            post_en_next = 1'b0;
            kind_next    = K_IDENT;
            len_next     = LW'(1);
            wr_now       = !flush_en;
            post_wr_next = flush_en;
            for (int w = 0; w < clt_pkg::NUM_KW; w++) begin
              match_next[w] = (clt_pkg::kw_char(4'(w), '0) == ch);
            end
          end else begin
            post_code_next = clt_pkg::TOK_ERROR;
            halted_next    = 1'b1;
          end
        end
      endcase
    end
  end

  // Token state and plan registers, updated when a character is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      kind   <= K_IDLE;
      len    <= '0;
      ovf    <= 1'b0;
      acc    <= '0;
      halted <= 1'b0;
      match  <= '1;
    end else if (fire) begin
      kind   <= kind_next;
      len    <= len_next;
      ovf    <= ovf_next;
      acc    <= acc_next;
      halted <= halted_next;
      match  <= match_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pre_code  <= pre_code_next;
      pre_value <= pre_value_next;
      f_code    <= f_code_next;
      f_len     <= f_len_next;
      f_ovf     <= f_ovf_next;
      post_code <= post_code_next;
      post_char <= ch;
    end
  end

  // Sequencer that moves the planned tokens into the output register.
  assign text_last = (LW'(fidx + 1'b1) == f_len);

  always_comb begin
    state_next = state;
    fidx_next  = fidx;
    load       = 1'b0;
    mem_re     = 1'b0;
    item       = '0;
    item.last  = 1'b1;
    unique case (state)
      S_IDLE: begin
        fidx_next = '0;
        if (fire) begin
          if (pre_en) begin
            state_next = S_PRE;
          end else if (flush_en) begin
            state_next = S_RD;
          end else if (post_en_next || post_wr_next) begin
            state_next = S_POST;
          end
        end
      end
      S_PRE: begin
        item.code  = pre_code;
        item.value = pre_value;
        if (free) begin
          load       = 1'b1;
          state_next = post_en ? S_POST : S_IDLE;
        end
      end
      S_RD: begin
        mem_re     = 1'b1;
        state_next = S_DAT;
      end
      S_DAT: begin
        item.code       = f_code;
        item.text_char  = mem_rdata;
        item.text_index = 5'(fidx);
        item.truncated  = f_ovf;
        item.last       = text_last;
        if (free) begin
          load      = 1'b1;
          fidx_next = fidx + 1'b1;
          if (text_last) begin
            state_next = (post_en || post_wr) ? S_POST : S_IDLE;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_POST: begin
        item.code = post_code;
        if (!post_en) begin
          state_next = S_IDLE;
        end else if (free) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      post_en <= 1'b0;
      post_wr <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        post_en <= post_en_next;
        post_wr <= post_wr_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    fidx <= fidx_next;
  end

  // Buffer writes: appends at acceptance, the held first character after a flush.
  assign mem_we    = (fire && wr_now) || ((state == S_POST) && post_wr);
  assign mem_waddr = (state == S_POST) ? '0 : wr_addr_now;
  assign mem_wdata = (state == S_POST) ? post_char : ch;

  clt_text_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (fidx[AW-1:0]),
    .rdata (mem_rdata)
  );

  clt_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .item     (item),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

/* src/clt_checker.sv */
// ----------------------------------------------------------------------------
// clt_checker
// Port-level checks on the lexer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module clt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic [6:0]  m_tuser,
  input wire logic        m_tlast
);

  // A held result keeps its payload until it is taken.
  `CLT_ASSERT(a_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))

  // Reset empties the output register.
  `CLT_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid)

  // Only integer tokens carry a value.
  `CLT_ASSERT(a_value_zero, clk, rst, (m_tvalid && (m_tuser[5:0] != clt_pkg::TOK_INT)) |-> (m_tdata[30:0] == 31'd0))

  // End, error and integer tokens are single transactions without text.
  `CLT_ASSERT(a_single, clk, rst, (m_tvalid && ((m_tuser[5:0] == clt_pkg::TOK_END) || (m_tuser[5:0] == clt_pkg::TOK_ERROR) || (m_tuser[5:0] == clt_pkg::TOK_INT))) |-> (m_tlast && (m_tdata[38:31] == 8'd0) && !m_tuser[6]))

  // No code above the error code is ever sent.
  `CLT_ASSERT(a_code_range, clk, rst, m_tvalid |-> (m_tuser[5:0] <= clt_pkg::TOK_ERROR))

endmodule

bind c_subset_lexer clt_checker u_clt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
